// ----- src/sbbm_pkg.sv -----
package sbbm_pkg;

    // Default widths, handed down as parameter defaults from the top level.
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 22;

    // Wet gain: Q1.16, unity is 2^16.
    localparam int WET_BITS = 17;
    localparam int WET_ONE  = 65536;

    // Configuration register indexes.
    localparam int REG_INDEX_BITS = 3;
    localparam logic [REG_INDEX_BITS-1:0] REG_COEF_B0 = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_COEF_B2 = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_COEF_A1 = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_COEF_A2 = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_WET_MIX = 3'd4;

    // Microprogram geometry.
    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] STEP_START = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_LAST  = 4'd9;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } seq_state_t;

    // Multiplier operand A: a coefficient or a mix gain.
    typedef enum logic [2:0] {
        A_B0,
        A_B2,
        A_A1,
        A_A2,
        A_DRY,
        A_WET
    } a_sel_t;

    // Multiplier operand B: a sample of the selected channel.
    typedef enum logic [2:0] {
        B_X0,
        B_XD2,
        B_YD1,
        B_YD2,
        B_Y0
    } b_sel_t;

    // What the accumulator does with the product registered in the step before.
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic                 mul_en;
        a_sel_t               a_sel;
        b_sel_t               b_sel;
        acc_op_t              acc_op;
        logic                 y_load;
        logic                 finish;
        logic                 jmp_chan;
        logic [STEP_BITS-1:0] jmp_target;
    } ucode_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        ucode_t op;
        logic   chan;
    } sbbm_ctrl_t;

    // Per-channel program. The accumulator works on the multiplier's product from the product register.
    function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
        ucode_t w;
        w = '0;
        case (step)
            4'd0:
            begin
                w.mul_en = 1'b1; w.a_sel = A_B0; w.b_sel = B_X0;
            end
            4'd1:
            begin
                w.mul_en = 1'b1; w.a_sel = A_B2; w.b_sel = B_XD2; w.acc_op = ACC_LOAD;
            end
            4'd2:
            begin
                w.mul_en = 1'b1; w.a_sel = A_A1; w.b_sel = B_YD1; w.acc_op = ACC_ADD;
            end
            4'd3:
            begin
                w.mul_en = 1'b1; w.a_sel = A_A2; w.b_sel = B_YD2; w.acc_op = ACC_SUB;
            end
            4'd4:
            begin
                w.acc_op = ACC_SUB;
            end
            4'd5:
            begin
                w.y_load = 1'b1;
            end
            4'd6:
            begin
                w.mul_en = 1'b1; w.a_sel = A_DRY; w.b_sel = B_X0;
            end
            4'd7:
            begin
                w.mul_en = 1'b1; w.a_sel = A_WET; w.b_sel = B_Y0; w.acc_op = ACC_LOAD;
            end
            4'd8:
            begin
                w.acc_op = ACC_ADD;
            end
            4'd9:
            begin
                w.finish = 1'b1; w.jmp_chan = 1'b1; w.jmp_target = STEP_START;
            end
            default:
            begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- src/sbbm_in_if.sv -----
interface sbbm_in_if import sbbm_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          right_enabled;
    logic                          last_in_block;

    modport source (
        output valid, left_sample, right_sample, right_enabled, last_in_block,
        input  ready
    );
    modport sink (
        input  valid, left_sample, right_sample, right_enabled, last_in_block,
        output ready
    );
endinterface

// ----- src/sbbm_out_if.sv -----
interface sbbm_out_if import sbbm_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          block_last;

    modport source (
        output valid, left_out, right_out, block_last,
        input  ready
    );
    modport sink (
        input  valid, left_out, right_out, block_last,
        output ready
    );
endinterface

// ----- src/stereo_bandpass_biquad_mix.sv -----
// Stereo bandpass biquad with dry/wet mix. One stereo frame per input beat gives
// one output beat. A shared multiplier runs a ten-step microprogram per filtered
// channel, and the right channel is filtered only when the frame enables it; when
// wet_mix is zero the frame skips the microprogram and passes straight through.
// The output register lets a finished beat wait while the next frame is taken.
// The user must write configuration only while idle; the block does not enforce it.
module stereo_bandpass_biquad_mix import sbbm_pkg::*; #(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    sbbm_in_if.sink                samples,
    sbbm_out_if.source             mixed,
    input  logic                   wr_en,
    input  logic [REG_INDEX_BITS-1:0] wr_index,
    input  logic [((COEF_FRAC_BITS + 2 > WET_BITS) ? COEF_FRAC_BITS + 2 : WET_BITS)-1:0] wr_data
);

    localparam int COEF_BITS = COEF_FRAC_BITS + 2;

    seq_state_t                    state_reg, state_next;
    logic [STEP_BITS-1:0]          step_reg, step_next;
    logic                          ch_reg, ch_next;
    logic                          out_valid_reg;

    logic signed [COEF_BITS-1:0]   b0_reg, b2_reg, a1_reg, a2_reg;
    logic        [WET_BITS-1:0]    wet_reg;
    logic        [WET_BITS-1:0]    wet_eff;

    logic signed [SAMPLE_BITS-1:0] x_l_reg, x_r_reg;
    logic                          r_en_reg, last_reg;
    logic signed [SAMPLE_BITS-1:0] res_l_reg, res_r_reg;
    logic signed [SAMPLE_BITS-1:0] out_l_reg, out_r_reg;
    logic                          out_last_reg;

    ucode_t                        word;
    sbbm_ctrl_t                    ctrl;
    logic signed [SAMPLE_BITS-1:0] mix_sample;
    logic                          in_beat;
    logic                          out_load;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg  <= '0;
            b2_reg  <= '0;
            a1_reg  <= '0;
            a2_reg  <= '0;
            wet_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_COEF_B0: b0_reg  <= signed'(wr_data[COEF_BITS-1:0]);
                REG_COEF_B2: b2_reg  <= signed'(wr_data[COEF_BITS-1:0]);
                REG_COEF_A1: a1_reg  <= signed'(wr_data[COEF_BITS-1:0]);
                REG_COEF_A2: a2_reg  <= signed'(wr_data[COEF_BITS-1:0]);
                REG_WET_MIX: wet_reg <= wr_data[WET_BITS-1:0];
                default:     wet_reg <= wet_reg;
            endcase
        end
    end

    // A wet gain above unity acts as unity.
    assign wet_eff = (wet_reg > WET_BITS'(WET_ONE)) ? WET_BITS'(WET_ONE) : wet_reg;

    assign samples.ready = (state_reg == ST_IDLE);
    assign in_beat       = samples.valid && samples.ready;
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || mixed.ready);

    assign word      = ucode_rom(step_reg);
    assign ctrl.op   = (state_reg == ST_RUN) ? word : '0;
    assign ctrl.chan = ch_reg;

    // Sequencer: step counter, channel select and the conditional jump.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ch_next    = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    step_next  = STEP_START;
                    ch_next    = 1'b0;
                    state_next = (wet_eff == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (word.jmp_chan)
                begin
                    if (!ch_reg && r_en_reg)
                    begin
                        ch_next   = 1'b1;
                        step_next = word.jmp_target;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_START;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ch_reg    <= ch_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (mixed.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Frame capture and per-channel results; unfiltered channels keep the input.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            x_l_reg   <= samples.left_sample;
            x_r_reg   <= samples.right_sample;
            r_en_reg  <= samples.right_enabled;
            last_reg  <= samples.last_in_block;
            res_l_reg <= samples.left_sample;
            res_r_reg <= samples.right_sample;
        end
        else if (ctrl.op.finish)
        begin
            if (ch_reg)
                res_r_reg <= mix_sample;
            else
                res_l_reg <= mix_sample;
        end
        if (out_load)
        begin
            out_l_reg    <= res_l_reg;
            out_r_reg    <= res_r_reg;
            out_last_reg <= last_reg;
        end
    end

    assign mixed.valid      = out_valid_reg;
    assign mixed.left_out   = out_l_reg;
    assign mixed.right_out  = out_r_reg;
    assign mixed.block_last = out_last_reg;

    sbbm_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .coef_b0    (b0_reg),
        .coef_b2    (b2_reg),
        .coef_a1    (a1_reg),
        .coef_a2    (a2_reg),
        .wet        (wet_eff),
        .x_left     (x_l_reg),
        .x_right    (x_r_reg),
        .mix_sample (mix_sample)
    );

    // A frame taken with zero wet gain goes straight to the output stage.
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (wet_eff == '0)) |=> (state_reg == ST_DONE))
        else $error("bypass frame entered the microprogram");

    // The step counter never runs past the end of the program.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= STEP_LAST))
        else $error("step counter beyond the microprogram");

    // The right channel is only filtered when the frame asked for it.
    a_right_only_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && ch_reg) |-> r_en_reg)
        else $error("right channel filtered while disabled");

    // A new output beat only appears after the sequencer has finished a frame.
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("output beat raised outside the done state");

endmodule

// ----- src/sbbm_datapath.sv -----
module sbbm_datapath import sbbm_pkg::*; #(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sbbm_ctrl_t                       ctrl,
    input  logic signed [COEF_FRAC_BITS+1:0] coef_b0,
    input  logic signed [COEF_FRAC_BITS+1:0] coef_b2,
    input  logic signed [COEF_FRAC_BITS+1:0] coef_a1,
    input  logic signed [COEF_FRAC_BITS+1:0] coef_a2,
    input  logic        [WET_BITS-1:0]       wet,
    input  logic signed [SAMPLE_BITS-1:0]    x_left,
    input  logic signed [SAMPLE_BITS-1:0]    x_right,
    output logic signed [SAMPLE_BITS-1:0]    mix_sample
);

    localparam int COEF_BITS = COEF_FRAC_BITS + 2;
    localparam int A_BITS    = (COEF_BITS > WET_BITS + 1) ? COEF_BITS : WET_BITS + 1;
    localparam int P_BITS    = A_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = P_BITS + 2;
    localparam logic signed [ACC_BITS-1:0] Y_HALF   = ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] MIX_HALF = ACC_BITS'(WET_ONE / 2);

    // Clamp to the signed sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] saturate(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if ((&v[ACC_BITS-1:SAMPLE_BITS-1]) || !(|v[ACC_BITS-1:SAMPLE_BITS-1]))
            r = v[SAMPLE_BITS-1:0];
        else if (v[ACC_BITS-1])
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        return r;
    endfunction

    logic signed [SAMPLE_BITS-1:0] xd1_reg [2];
    logic signed [SAMPLE_BITS-1:0] xd2_reg [2];
    logic signed [SAMPLE_BITS-1:0] yd1_reg [2];
    logic signed [SAMPLE_BITS-1:0] yd2_reg [2];
    logic signed [SAMPLE_BITS-1:0] y0_reg;
    logic signed [P_BITS-1:0]      prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;

    logic        [WET_BITS:0]      dry_gain;
    logic signed [A_BITS-1:0]      a_op;
    logic signed [SAMPLE_BITS-1:0] b_op;
    logic signed [SAMPLE_BITS-1:0] x0;
    logic signed [P_BITS-1:0]      product;
    logic signed [ACC_BITS-1:0]    y_rounded;
    logic signed [ACC_BITS-1:0]    mix_rounded;

    assign x0       = ctrl.chan ? x_right : x_left;
    assign dry_gain = (WET_BITS + 1)'(WET_ONE) - {1'b0, wet};

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (ctrl.op.a_sel)
            A_B0:    a_op = A_BITS'(coef_b0);
            A_B2:    a_op = A_BITS'(coef_b2);
            A_A1:    a_op = A_BITS'(coef_a1);
            A_A2:    a_op = A_BITS'(coef_a2);
            A_DRY:   a_op = A_BITS'(signed'(dry_gain));
            A_WET:   a_op = A_BITS'(signed'({1'b0, wet}));
            default: a_op = '0;
        endcase
        case (ctrl.op.b_sel)
            B_X0:    b_op = x0;
            B_XD2:   b_op = xd2_reg[ctrl.chan];
            B_YD1:   b_op = yd1_reg[ctrl.chan];
            B_YD2:   b_op = yd2_reg[ctrl.chan];
            B_Y0:    b_op = y0_reg;
            default: b_op = '0;
        endcase
    end

    assign product = a_op * b_op;

    // Rounding half up, then saturation, for the biquad output and for the mix.
    assign y_rounded   = (acc_reg + Y_HALF) >>> COEF_FRAC_BITS;
    assign mix_rounded = (acc_reg + MIX_HALF) >>> 16;
    assign mix_sample  = saturate(mix_rounded);

    // Product register and accumulator.
    always_ff @(posedge clk)
    begin
        if (ctrl.op.mul_en)
            prod_reg <= product;
        case (ctrl.op.acc_op)
            ACC_LOAD: acc_reg <= ACC_BITS'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + ACC_BITS'(prod_reg);
            ACC_SUB:  acc_reg <= acc_reg - ACC_BITS'(prod_reg);
            default:  acc_reg <= acc_reg;
        endcase
        if (ctrl.op.y_load)
            y0_reg <= saturate(y_rounded);
    end

    // Filter history, shifted once per filtered channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                xd1_reg[i] <= '0;
                xd2_reg[i] <= '0;
                yd1_reg[i] <= '0;
                yd2_reg[i] <= '0;
            end
        end
        else if (ctrl.op.finish)
        begin
            xd2_reg[ctrl.chan] <= xd1_reg[ctrl.chan];
            xd1_reg[ctrl.chan] <= x0;
            yd2_reg[ctrl.chan] <= yd1_reg[ctrl.chan];
            yd1_reg[ctrl.chan] <= y0_reg;
        end
    end

endmodule

// ----- test/tb_stereo_bandpass_biquad_mix.sv -----
module tb_stereo_bandpass_biquad_mix import sbbm_pkg::*; ();

    localparam int SB          = DEF_SAMPLE_BITS;
    localparam int CF          = DEF_COEF_FRAC_BITS;
    localparam int COEF_BITS   = CF + 2;
    localparam int WR_BITS     = (COEF_BITS > WET_BITS) ? COEF_BITS : WET_BITS;
    localparam int MIX_SHIFT   = 16;
    localparam int CH_LEFT     = 0;
    localparam int CH_RIGHT    = 1;

    localparam int ROW_COUNT       = 21;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 242;
    localparam int SETTLE_CYCLES   = 32;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef logic signed [SB-1:0]        sample_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic [WET_BITS-1:0]         wet_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam coef_t   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam coef_t   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam coef_t   COEF_ONE   = coef_t'(1) <<< CF;
    localparam wet_t    WET_UNITY  = wet_t'(WET_ONE);
    localparam wet_t    WET_TOP    = {WET_BITS{1'b1}};

    // A narrow bandpass around a tenth of the Nyquist rate, Q of about two.
    localparam coef_t BP_B0 = 24'sd300733;
    localparam coef_t BP_B2 = -24'sd300733;
    localparam coef_t BP_A1 = -24'sd7405300;
    localparam coef_t BP_A2 = 24'sd3592400;

    typedef struct {
        coef_t b0;
        coef_t b2;
        coef_t a1;
        coef_t a2;
        wet_t  wet;
    } setting_t;

    typedef struct {
        sample_t left;
        sample_t right;
        logic    right_on;
        logic    last;
    } frame_t;

    typedef struct {
        sample_t left;
        sample_t right;
        logic    last;
    } mixed_t;

    typedef struct {
        sample_t xd1;
        sample_t xd2;
        sample_t yd1;
        sample_t yd2;
    } chan_hist_t;

    typedef struct {
        int      sel;
        sample_t left;
        sample_t right;
        logic    right_on;
        logic    last;
        bit      known;
        sample_t want_left;
        sample_t want_right;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic wr_en;
    logic [REG_INDEX_BITS-1:0] wr_index;
    logic [WR_BITS-1:0] wr_data;

    sbbm_in_if  samples_if ();
    sbbm_out_if mixed_if ();

    stereo_bandpass_biquad_mix dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_if),
        .mixed    (mixed_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Register settings used by the directed part.
    setting_t dir_settings [6] = '{
        '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 17'd0},
        '{COEF_MAX, 24'sd0, 24'sd0, 24'sd0, WET_UNITY},
        '{COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, WET_TOP},
        '{BP_B0, BP_B2, BP_A1, BP_A2, 17'd32768},
        '{COEF_ONE, COEF_MIN, COEF_MAX, COEF_MIN, 17'd1},
        '{BP_B0, BP_B2, BP_A1, BP_A2, 17'd0}
    };

    // Directed frames; rows with known set carry their result typed in.
    stim_row_t stim_rows [ROW_COUNT] = '{
        // Reset settings: zero wet gain, so every frame passes straight through.
        '{0, 24'sd0, 24'sd0, 1'b0, 1'b0, 1'b1, 24'sd0, 24'sd0},
        '{0, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b1, 1'b1, SAMPLE_MAX, SAMPLE_MIN},
        '{0, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b0, 1'b1, SAMPLE_MIN, SAMPLE_MAX},
        '{0, 24'sd1, -24'sd1, 1'b1, 1'b0, 1'b1, 24'sd1, -24'sd1},
        // Gain of almost two, fully wet: full-scale inputs saturate the biquad.
        '{1, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b0, 1'b1, SAMPLE_MAX, SAMPLE_MAX},
        '{1, SAMPLE_MIN, SAMPLE_MIN, 1'b1, 1'b1, 1'b1, SAMPLE_MIN, SAMPLE_MIN},
        '{1, 24'sd1000, 24'sd5, 1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
        '{1, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b1, 1'b1, SAMPLE_MIN, SAMPLE_MAX},
        // Extreme coefficients with a wet gain above unity.
        '{2, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0, 1'b0, 24'sd0, 24'sd0},
        '{2, SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b1, 1'b0, 24'sd0, 24'sd0},
        '{2, 24'sd0, 24'sd0, 1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
        '{2, 24'sd12345, -24'sd54321, 1'b1, 1'b0, 1'b0, 24'sd0, 24'sd0},
        // A real bandpass at half wet.
        '{3, 24'sd1000000, -24'sd1000000, 1'b1, 1'b0, 1'b0, 24'sd0, 24'sd0},
        '{3, 24'sd0, 24'sd0, 1'b1, 1'b0, 1'b0, 24'sd0, 24'sd0},
        '{3, 24'sd0, 24'sd0, 1'b1, 1'b0, 1'b0, 24'sd0, 24'sd0},
        '{3, -24'sd4000000, 24'sd4000000, 1'b1, 1'b1, 1'b0, 24'sd0, 24'sd0},
        '{3, 24'sd500, -24'sd500, 1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
        // Smallest non-zero wet gain.
        '{4, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0, 1'b0, 24'sd0, 24'sd0},
        '{4, SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b1, 1'b0, 24'sd0, 24'sd0},
        // Bypass with live coefficients: outputs follow inputs, history is held.
        '{5, 24'sd777, -24'sd777, 1'b1, 1'b0, 1'b1, 24'sd777, -24'sd777},
        '{5, SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b1, 1'b1, SAMPLE_MIN, SAMPLE_MAX}
    };

    setting_t   active_cfg;
    chan_hist_t history [2];
    mixed_t     pending_mixes [$];
    int         mismatch_count = 0;
    int         mixed_beats = 0;
    int         stall_pct = 0;
    int         hold_left = 0;
    int         quiet_cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic sample_t clamp_sample(input longint v);
        if (v > longint'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (v < longint'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return sample_t'(v);
    endfunction

    // One channel: biquad, history update, then the dry/wet blend.
    function automatic sample_t filter_channel(input int ch, input sample_t x0,
                                               input longint wet);
        longint  acc;
        longint  blend;
        sample_t y0;
        acc = longint'(active_cfg.b0) * longint'(x0)
            + longint'(active_cfg.b2) * longint'(history[ch].xd2)
            - longint'(active_cfg.a1) * longint'(history[ch].yd1)
            - longint'(active_cfg.a2) * longint'(history[ch].yd2);
        y0 = clamp_sample((acc + (longint'(1) <<< (CF - 1))) >>> CF);
        history[ch].xd2 = history[ch].xd1;
        history[ch].xd1 = x0;
        history[ch].yd2 = history[ch].yd1;
        history[ch].yd1 = y0;
        blend = (longint'(WET_ONE) - wet) * longint'(x0) + wet * longint'(y0)
              + longint'(WET_ONE / 2);
        return clamp_sample(blend >>> MIX_SHIFT);
    endfunction

    // Whole frame: a wet gain above unity counts as unity, zero bypasses.
    function automatic mixed_t mix_frame(input frame_t f);
        longint wet;
        mixed_t r;
        wet = (longint'(active_cfg.wet) > WET_ONE) ? WET_ONE : longint'(active_cfg.wet);
        r = '{left: f.left, right: f.right, last: f.last};
        if (wet != 0)
        begin
            r.left = filter_channel(CH_LEFT, f.left, wet);
            if (f.right_on)
                r.right = filter_channel(CH_RIGHT, f.right, wet);
        end
        return r;
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2, 3: return sample_t'(int'($urandom_range(0, 4000)) - 2000);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        f.left     = random_sample();
        f.right    = random_sample();
        f.right_on = ($urandom_range(0, 3) != 0);
        f.last     = ($urandom_range(0, 7) == 0);
        return f;
    endfunction

    // Narrow coefficients stay within plus or minus one.
    function automatic coef_t random_coef(input bit narrow);
        if (narrow)
            return coef_t'(int'($urandom_range(0, 2 * int'(COEF_ONE))) - int'(COEF_ONE));
        return coef_t'($urandom);
    endfunction

    function automatic setting_t random_setting(input int phase);
        setting_t s;
        s = '{BP_B0, BP_B2, BP_A1, BP_A2, wet_t'($urandom_range(1, WET_ONE - 1))};
        case (phase)
            1:
            begin
                s = '{random_coef(0), random_coef(0), random_coef(0), random_coef(0),
                      WET_UNITY};
            end
            2:
            begin
                s = '{random_coef(1), random_coef(1), random_coef(1), random_coef(1),
                      wet_t'($urandom_range(0, int'(WET_TOP)))};
            end
            3:
            begin
                s = '{random_coef(0), random_coef(0), random_coef(0), random_coef(0),
                      17'd0};
            end
            4: s = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, WET_UNITY - 17'd1};
            5: s.wet = WET_TOP;
            6: s = '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 17'd1};
            7:
            begin
                s.b0  = BP_B0 + random_coef(1) / 16;
                s.a1  = BP_A1 + random_coef(1) / 64;
                s.wet = wet_t'($urandom_range(0, int'(WET_TOP)));
            end
            default: s.wet = wet_t'($urandom_range(1, WET_ONE - 1));
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at output beat %0d: %s", mixed_beats, msg);
    endtask

    // Writes every register back to back; the block must be idle.
    task automatic write_registers(input setting_t s);
        wr_en    <= 1'b1;
        wr_index <= REG_COEF_B0;
        wr_data  <= WR_BITS'(s.b0);
        @(posedge clk);
        wr_index <= REG_COEF_B2;
        wr_data  <= WR_BITS'(s.b2);
        @(posedge clk);
        wr_index <= REG_COEF_A1;
        wr_data  <= WR_BITS'(s.a1);
        @(posedge clk);
        wr_index <= REG_COEF_A2;
        wr_data  <= WR_BITS'(s.a2);
        @(posedge clk);
        wr_index <= REG_WET_MIX;
        wr_data  <= WR_BITS'(s.wet);
        @(posedge clk);
        wr_en <= 1'b0;
        active_cfg = s;
    endtask

    // Drain every pending mix, then give the sequencer time to go idle.
    task automatic wait_until_idle();
        while (pending_mixes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offers one frame, possibly after idle cycles, and queues its expected mix.
    task automatic send_frame(input frame_t f, input int gap_pct, input bit typed,
                              input mixed_t typed_mix);
        mixed_t predicted;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid         <= 1'b1;
        samples_if.left_sample   <= f.left;
        samples_if.right_sample  <= f.right;
        samples_if.right_enabled <= f.right_on;
        samples_if.last_in_block <= f.last;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        predicted = mix_frame(f);
        pending_mixes.push_back(typed ? typed_mix : predicted);
    endtask

    // Output ready: random stalls, or a long hold-off when one is requested.
    initial
    begin
        mixed_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                mixed_if.ready <= 1'b0;
                hold_left--;
            end
            else
                mixed_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Each output beat is checked against the oldest pending mix.
    always @(posedge clk)
    begin : check_beats
        mixed_t want;
        if (rst_n && mixed_if.valid && mixed_if.ready)
        begin
            if (pending_mixes.size() == 0)
                report_mismatch("output beat with no frame outstanding");
            else
            begin
                want = pending_mixes.pop_front();
                if (mixed_if.left_out !== want.left)
                    report_mismatch($sformatf("left_out expected %0d, got %0d",
                                              want.left, mixed_if.left_out));
                if (mixed_if.right_out !== want.right)
                    report_mismatch($sformatf("right_out expected %0d, got %0d",
                                              want.right, mixed_if.right_out));
                if (mixed_if.block_last !== want.last)
                    report_mismatch($sformatf("block_last expected %0b, got %0b",
                                              want.last, mixed_if.block_last));
            end
            mixed_beats++;
        end
    end

    // Ends the run when no beat moves on either side for too long.
    initial
    begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((samples_if.valid && samples_if.ready) || (mixed_if.valid && mixed_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        frame_t f;
        mixed_t typed;
        int     cur_sel;
        int     gap_pct;
        rst_n                    = 1'b0;
        wr_en                    = 1'b0;
        wr_index                 = REG_COEF_B0;
        wr_data                  = '0;
        samples_if.valid         = 1'b0;
        samples_if.left_sample   = '0;
        samples_if.right_sample  = '0;
        samples_if.right_enabled = 1'b0;
        samples_if.last_in_block = 1'b0;
        active_cfg = dir_settings[0];
        for (int c = 0; c < 2; c++)
            history[c] = '{default: '0};
        cur_sel = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames, with no idling on either side.
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            if (stim_rows[i].sel != cur_sel)
            begin
                samples_if.valid <= 1'b0;
                wait_until_idle();
                write_registers(dir_settings[stim_rows[i].sel]);
                cur_sel = stim_rows[i].sel;
            end
            f = '{left: stim_rows[i].left, right: stim_rows[i].right,
                  right_on: stim_rows[i].right_on, last: stim_rows[i].last};
            typed = '{left: stim_rows[i].want_left, right: stim_rows[i].want_right,
                      last: stim_rows[i].last};
            send_frame(f, 0, stim_rows[i].known, typed);
        end
        samples_if.valid <= 1'b0;

        // Random phases: new settings each time, idling pattern rotating.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_until_idle();
            write_registers(random_setting(p));
            case (p % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 50;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 50;
                end
                default:
                begin
                    gap_pct   = 31;
                    stall_pct = 31;
                end
            endcase
            // Hold the output back while frames keep coming, so the input backs up.
            if (p == 4)
                hold_left = HOLD_CYCLES;
            typed = '{left: '0, right: '0, last: 1'b0};
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_frame(random_frame(), gap_pct, 1'b0, typed);
            samples_if.valid <= 1'b0;
        end

        wait_until_idle();
        if (mismatch_count == 0 && pending_mixes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
